### src/gamepad_serial_command_responder_macros.svh
// Assertion macros used by the answer stage.
`ifndef GAMEPAD_SERIAL_COMMAND_RESPONDER_MACROS_SVH
`define GAMEPAD_SERIAL_COMMAND_RESPONDER_MACROS_SVH

// A condition that holds at every clock edge out of reset.
`define GSC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A consequence that holds in the same cycle as its antecedent.
`define GSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that holds in the cycle after its antecedent.
`define GSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/gsc_pkg.sv
// Types, constants and helper functions of the game-pad command responder.
package gsc_pkg;

  localparam int NUM_PORTS      = 2;
  localparam int PORT_W         = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int PRESS_PER_PORT = 12;
  localparam int PADDR_W        = 3;

  localparam logic [0:0] OP_START    = 1'b0;
  localparam logic [0:0] OP_EXCHANGE = 1'b1;

  localparam logic [7:0] CMD_MASK_INFO  = 8'h40;
  localparam logic [7:0] CMD_STATUS     = 8'h41;
  localparam logic [7:0] CMD_READ_DATA  = 8'h42;
  localparam logic [7:0] CMD_CONFIG     = 8'h43;
  localparam logic [7:0] CMD_SET_MODE   = 8'h44;
  localparam logic [7:0] CMD_QUERY_MODEL = 8'h45;
  localparam logic [7:0] CMD_QUERY_ACT  = 8'h46;
  localparam logic [7:0] CMD_QUERY_COMB = 8'h47;
  localparam logic [7:0] CMD_QUERY_MODE = 8'h4C;
  localparam logic [7:0] CMD_VIBRATION  = 8'h4D;
  localparam logic [7:0] CMD_NATIVE     = 8'h4F;

  localparam logic [7:0] ANS_START      = 8'hFF;
  localparam logic [7:0] ANS_CONFIG     = 8'hF3;
  localparam logic [7:0] ANS_MARK       = 8'h5A;
  localparam logic [7:0] ANS_FULL       = 8'hFF;
  localparam logic [7:0] ANS_ZERO       = 8'h00;
  localparam logic [7:0] ID_DIGITAL     = 8'h41;
  localparam logic [7:0] ID_ANALOG      = 8'h73;
  localparam logic [7:0] ID_NATIVE      = 8'h79;
  localparam logic [7:0] ACT_LONG       = 8'h14;
  localparam logic [7:0] ACT_SHORT      = 8'h0A;
  localparam logic [7:0] MQ_ANS_ONE     = 8'h04;
  localparam logic [7:0] MQ_ANS_TWO     = 8'h07;

  localparam logic [7:0] MODE_DIGITAL   = 8'd0;
  localparam logic [7:0] MODE_ANALOG    = 8'd1;

  localparam logic [4:0] FRAME_NONE     = 5'd0;
  localparam logic [4:0] FRAME_DIGITAL  = 5'd4;
  localparam logic [4:0] FRAME_FIXED    = 5'd8;
  localparam logic [4:0] FRAME_ANALOG   = 5'd20;

  localparam logic [6:0] PCT_RESET      = 7'd100;
  localparam logic [31:0] PCT_RECIP     = 32'd41944;
  localparam int         PCT_SHIFT      = 22;

  typedef struct packed {
    logic [0:0]  opcode;
    logic [1:0]  port_number;
    logic [7:0]  tx_byte;
    logic [15:0] buttons;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  // Pressure level: percent times 255 over 100, saturated at 255.
  function automatic logic [7:0] press_level(input logic [6:0] pct);
    logic [14:0] prod;
    logic [31:0] quot;
    prod = (15'(pct) << 8) - 15'(pct);
    quot = (32'(prod) * PCT_RECIP) >> PCT_SHIFT;
    return (quot > 32'd255) ? 8'hFF : quot[7:0];
  endfunction

endpackage

### src/gsc_ifs.sv
// Word channels of the responder: host bytes in, pad answers out.
interface gsc_in_if;
  logic        valid;
  logic        ready;
  logic [0:0]  opcode;
  logic [1:0]  port_number;
  logic [7:0]  tx_byte;
  logic [15:0] buttons;
  logic [7:0]  right_x;
  logic [7:0]  right_y;
  logic [7:0]  left_x;
  logic [7:0]  left_y;

  modport source (output valid, opcode, port_number, tx_byte, buttons, right_x, right_y,
                  left_x, left_y, input ready);
  modport sink (input valid, opcode, port_number, tx_byte, buttons, right_x, right_y,
                left_x, left_y, output ready);
endinterface

interface gsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, rx_byte, input ready);
  modport sink (input valid, rx_byte, output ready);
endinterface

### src/gsc_cfg.sv
// Configuration register port holding the pressure percentage and its level.
module gsc_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gsc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic [7:0]                   level_o
);

  logic [6:0] pct_q, pct_d;
  logic [7:0] lvl_q, lvl_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

  always_comb begin
    pct_d = pct_q;
    lvl_d = lvl_q;
    if (wr_en) begin
      pct_d = pwdata[6:0];
      lvl_d = gsc_pkg::press_level(pwdata[6:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pct_q <= gsc_pkg::PCT_RESET;
      lvl_q <= gsc_pkg::press_level(gsc_pkg::PCT_RESET);
    end else begin
      pct_q <= pct_d;
      lvl_q <= lvl_d;
    end
  end

  assign prdata  = (paddr[2] == 1'b0) ? {25'd0, pct_q} : 32'd0;
  assign level_o = lvl_q;

endmodule

### src/gsc_in_reg.sv
// Input register that holds one host word until the answer stage takes it.
module gsc_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  gsc_pkg::item_t  in_item_i,
  input  logic            take_i,
  output gsc_pkg::stage_t stage_o
);

  logic           valid_q, valid_d;
  gsc_pkg::item_t item_q;
  logic           load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule

### src/gsc_resp.sv
// Answer stage: pad state, frame decoding and the result register.
`include "gamepad_serial_command_responder_macros.svh"

module gsc_resp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  gsc_pkg::stage_t stage_i,
  input  logic [7:0]      level_i,
  output logic            take_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      rx_byte_o
);

  localparam int NP = gsc_pkg::NUM_PORTS;
  localparam int PP = gsc_pkg::PRESS_PER_PORT;
  localparam int PW = gsc_pkg::PORT_W;

  logic [7:0]    mode_q [NP];
  logic [7:0]    mode_d [NP];
  logic [7:0]    ident_q [NP];
  logic [7:0]    ident_d [NP];
  logic          cfg_ent_q [NP];
  logic          cfg_ent_d [NP];
  logic          pvar_q [NP];
  logic          pvar_d [NP];
  logic [1:0]    mq_q [NP];
  logic [1:0]    mq_d [NP];
  logic [7:0]    press_q [NP][PP];
  logic [7:0]    press_d [NP][PP];
  logic          native_q, native_d;
  logic [15:0]   snap_btn_q, snap_btn_d;
  logic [7:0]    snap_rx_q, snap_rx_d, snap_ry_q, snap_ry_d;
  logic [7:0]    snap_lx_q, snap_lx_d, snap_ly_q, snap_ly_d;
  logic [PW-1:0] port_q, port_d;
  logic [4:0]    idx_q, idx_d;
  logic [7:0]    cmd_q, cmd_d;
  logic [4:0]    flen_q, flen_d;
  logic          out_v_q, out_v_d;
  logic [7:0]    rx_q;

  gsc_pkg::item_t it;
  logic           fire;
  logic [7:0]     ans;
  logic [7:0]     v;
  logic [PW-1:0]  p;
  logic [4:0]     pidx;
  logic [3:0]     pslot;
  logic [3:0]     hi_slot, lo_slot;
  logic           hi_hit, lo_hit;

  assign it     = stage_i.item;
  assign take_o = !out_v_q || out_ready_i;
  assign fire   = stage_i.valid && take_o;
  assign v      = it.tx_byte;
  assign p      = port_q;
  assign pidx   = idx_q - 5'd8;
  assign pslot  = pidx[3:0];

  always_comb begin
    lo_hit  = 1'b1;
    lo_slot = 4'd0;
    case (it.buttons[7:0])
      8'hBF:   lo_slot = 4'd6;
      8'hDF:   lo_slot = 4'd5;
      8'hEF:   lo_slot = 4'd4;
      8'h7F:   lo_slot = 4'd7;
      8'hFB:   lo_slot = 4'd8;
      8'hF7:   lo_slot = 4'd9;
      8'hFE:   lo_slot = 4'd10;
      8'hFD:   lo_slot = 4'd11;
      default: lo_hit  = 1'b0;
    endcase
    hi_hit  = 1'b1;
    hi_slot = 4'd0;
    case (it.buttons[15:12])
      4'hE:    hi_slot = 4'd2;
      4'hB:    hi_slot = 4'd3;
      4'h7:    hi_slot = 4'd1;
      4'hD:    hi_slot = 4'd0;
      default: hi_hit  = 1'b0;
    endcase
  end

  always_comb begin
    mode_d     = mode_q;
    ident_d    = ident_q;
    cfg_ent_d  = cfg_ent_q;
    pvar_d     = pvar_q;
    mq_d       = mq_q;
    press_d    = press_q;
    native_d   = native_q;
    snap_btn_d = snap_btn_q;
    snap_rx_d  = snap_rx_q;
    snap_ry_d  = snap_ry_q;
    snap_lx_d  = snap_lx_q;
    snap_ly_d  = snap_ly_q;
    port_d     = port_q;
    idx_d      = idx_q;
    cmd_d      = cmd_q;
    flen_d     = flen_q;
    ans        = gsc_pkg::ANS_ZERO;

    if (it.opcode == gsc_pkg::OP_START) begin
      if ((it.port_number != 2'd0) && (32'(it.port_number) <= NP)) begin
        port_d = PW'(it.port_number - 2'd1);
      end
      idx_d = 5'd0;
      ans   = gsc_pkg::ANS_START;
    end else if (idx_q == 5'd0) begin
      idx_d  = 5'd1;
      cmd_d  = v;
      flen_d = gsc_pkg::FRAME_FIXED;
      ans    = gsc_pkg::ANS_CONFIG;
      unique case (v) inside
        gsc_pkg::CMD_MASK_INFO, gsc_pkg::CMD_STATUS, gsc_pkg::CMD_SET_MODE,
        gsc_pkg::CMD_QUERY_MODEL, gsc_pkg::CMD_QUERY_ACT, gsc_pkg::CMD_QUERY_COMB,
        gsc_pkg::CMD_QUERY_MODE, gsc_pkg::CMD_VIBRATION: begin
        end
        gsc_pkg::CMD_READ_DATA: begin
          snap_btn_d = it.buttons;
          snap_rx_d  = it.right_x;
          snap_ry_d  = it.right_y;
          snap_lx_d  = it.left_x;
          snap_ly_d  = it.left_y;
          for (int i = 4; i < PP; i++) begin
            if (lo_hit) begin
              if (lo_slot == 4'(i)) press_d[p][i] = level_i;
            end else begin
              press_d[p][i] = 8'd0;
            end
          end
          for (int i = 0; i < 4; i++) begin
            if (hi_hit) begin
              if (hi_slot == 4'(i)) press_d[p][i] = level_i;
            end else begin
              press_d[p][i] = 8'd0;
            end
          end
          flen_d = (mode_q[p] == gsc_pkg::MODE_ANALOG) ? gsc_pkg::FRAME_ANALOG :
                                                         gsc_pkg::FRAME_DIGITAL;
          ans    = ident_q[p];
        end
        gsc_pkg::CMD_CONFIG: begin
          if (!cfg_ent_q[p]) ans = ident_q[p];
        end
        gsc_pkg::CMD_NATIVE: begin
          ident_d[p] = gsc_pkg::ID_NATIVE;
          native_d   = 1'b1;
        end
        default: begin
          flen_d = gsc_pkg::FRAME_NONE;
          ans    = gsc_pkg::ANS_ZERO;
        end
      endcase
    end else begin
      if (idx_q == 5'd2) begin
        case (cmd_q)
          gsc_pkg::CMD_CONFIG: begin
            if (v <= 8'd1) cfg_ent_d[p] = v[0];
          end
          gsc_pkg::CMD_SET_MODE: begin
            mode_d[p] = v;
            if (v == gsc_pkg::MODE_DIGITAL) begin
              ident_d[p] = gsc_pkg::ID_DIGITAL;
            end else if (v == gsc_pkg::MODE_ANALOG) begin
              ident_d[p] = native_q ? gsc_pkg::ID_NATIVE : gsc_pkg::ID_ANALOG;
            end
          end
          gsc_pkg::CMD_QUERY_ACT: begin
            if (v <= 8'd1) pvar_d[p] = v[0];
          end
          gsc_pkg::CMD_QUERY_MODE: begin
            if (v <= 8'd1) mq_d[p] = v[1:0] + 2'd1;
          end
          default: begin
          end
        endcase
      end
      if (idx_q < flen_q) begin
        idx_d = idx_q + 5'd1;
        if (idx_q == 5'd1) begin
          ans = gsc_pkg::ANS_MARK;
        end else begin
          case (cmd_q)
            gsc_pkg::CMD_MASK_INFO: begin
              case (idx_q[2:0])
                3'd4:    ans = 8'd2;
                3'd7:    ans = gsc_pkg::ANS_MARK;
                default: ans = gsc_pkg::ANS_ZERO;
              endcase
            end
            gsc_pkg::CMD_STATUS: begin
              case (idx_q[2:0])
                3'd2, 3'd3: ans = gsc_pkg::ANS_FULL;
                3'd4:       ans = 8'd3;
                3'd7:       ans = gsc_pkg::ANS_MARK;
                default:    ans = gsc_pkg::ANS_ZERO;
              endcase
            end
            gsc_pkg::CMD_READ_DATA: begin
              if (idx_q == 5'd2) ans = snap_btn_q[15:8];
              else if (idx_q == 5'd3) ans = snap_btn_q[7:0];
              else if (idx_q == 5'd4) ans = snap_rx_q;
              else if (idx_q == 5'd5) ans = snap_ry_q;
              else if (idx_q == 5'd6) ans = snap_lx_q;
              else if (idx_q == 5'd7) ans = snap_ly_q;
              else if (idx_q < gsc_pkg::FRAME_ANALOG) ans = press_q[p][pslot];
              else ans = gsc_pkg::ANS_ZERO;
            end
            gsc_pkg::CMD_CONFIG: begin
              if ((idx_q == 5'd2) || (idx_q == 5'd3)) begin
                ans = cfg_ent_d[p] ? gsc_pkg::ANS_FULL : gsc_pkg::ANS_ZERO;
              end
            end
            gsc_pkg::CMD_QUERY_MODEL: begin
              case (idx_q[2:0])
                3'd2:    ans = 8'd3;
                3'd3:    ans = 8'd2;
                3'd4:    ans = mode_d[p];
                3'd5:    ans = 8'd2;
                3'd6:    ans = 8'd1;
                default: ans = gsc_pkg::ANS_ZERO;
              endcase
            end
            gsc_pkg::CMD_QUERY_ACT: begin
              case (idx_q[2:0])
                3'd4:    ans = 8'd1;
                3'd5:    ans = pvar_d[p] ? 8'd1 : 8'd2;
                3'd6:    ans = pvar_d[p] ? 8'd1 : 8'd0;
                3'd7:    ans = pvar_d[p] ? gsc_pkg::ACT_LONG : gsc_pkg::ACT_SHORT;
                default: ans = gsc_pkg::ANS_ZERO;
              endcase
            end
            gsc_pkg::CMD_QUERY_COMB: begin
              case (idx_q[2:0])
                3'd4:    ans = 8'd2;
                3'd6:    ans = 8'd1;
                default: ans = gsc_pkg::ANS_ZERO;
              endcase
            end
            gsc_pkg::CMD_QUERY_MODE: begin
              if (idx_q == 5'd5) begin
                case (mq_d[p])
                  2'd1:    ans = gsc_pkg::MQ_ANS_ONE;
                  2'd2:    ans = gsc_pkg::MQ_ANS_TWO;
                  default: ans = gsc_pkg::ANS_ZERO;
                endcase
              end
            end
            gsc_pkg::CMD_VIBRATION: ans = gsc_pkg::ANS_FULL;
            gsc_pkg::CMD_NATIVE: begin
              if (idx_q == 5'd7) ans = gsc_pkg::ANS_MARK;
            end
            default: ans = gsc_pkg::ANS_ZERO;
          endcase
        end
      end
    end
  end

  always_comb begin
    out_v_d = out_v_q;
    if (fire) begin
      out_v_d = 1'b1;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NP; i++) begin
        mode_q[i]    <= gsc_pkg::MODE_DIGITAL;
        ident_q[i]   <= gsc_pkg::ID_DIGITAL;
        cfg_ent_q[i] <= 1'b0;
        pvar_q[i]    <= 1'b0;
        mq_q[i]      <= 2'd0;
        for (int j = 0; j < PP; j++) begin
          press_q[i][j] <= 8'd0;
        end
      end
      native_q   <= 1'b0;
      snap_btn_q <= 16'hFFFF;
      snap_rx_q  <= 8'h80;
      snap_ry_q  <= 8'h80;
      snap_lx_q  <= 8'h80;
      snap_ly_q  <= 8'h80;
      port_q     <= '0;
      idx_q      <= 5'd0;
      cmd_q      <= 8'd0;
      flen_q     <= gsc_pkg::FRAME_NONE;
      out_v_q    <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      if (fire) begin
        mode_q     <= mode_d;
        ident_q    <= ident_d;
        cfg_ent_q  <= cfg_ent_d;
        pvar_q     <= pvar_d;
        mq_q       <= mq_d;
        press_q    <= press_d;
        native_q   <= native_d;
        snap_btn_q <= snap_btn_d;
        snap_rx_q  <= snap_rx_d;
        snap_ry_q  <= snap_ry_d;
        snap_lx_q  <= snap_lx_d;
        snap_ly_q  <= snap_ly_d;
        port_q     <= port_d;
        idx_q      <= idx_d;
        cmd_q      <= cmd_d;
        flen_q     <= flen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rx_q <= ans;
    end
  end

  assign out_valid_o = out_v_q;
  assign rx_byte_o   = rx_q;

  `GSC_ASSERT_ALWAYS(a_idx_range, idx_q <= gsc_pkg::FRAME_ANALOG, "byte index past longest frame")
  `GSC_ASSERT_ALWAYS(a_flen_code, (flen_q == gsc_pkg::FRAME_NONE) || (flen_q == gsc_pkg::FRAME_DIGITAL) || (flen_q == gsc_pkg::FRAME_FIXED) || (flen_q == gsc_pkg::FRAME_ANALOG), "bad frame length")
  `GSC_ASSERT_NXT(a_start, fire && (it.opcode == gsc_pkg::OP_START), out_v_q && (idx_q == 5'd0) && (rx_q == gsc_pkg::ANS_START), "start word not answered")
  `GSC_ASSERT_NXT(a_read_len, fire && (it.opcode == gsc_pkg::OP_EXCHANGE) && (idx_q == 5'd0) && (v == gsc_pkg::CMD_READ_DATA), (flen_q == gsc_pkg::FRAME_DIGITAL) || (flen_q == gsc_pkg::FRAME_ANALOG), "read frame length wrong")

endmodule

### src/gamepad_serial_command_responder.sv
// A word passes the input register and then the answer stage's result register.
// Throughput: one word per cycle while the output is ready, via a single answer stage.
// The input register takes a new word while a finished answer waits at the output, if it is empty.
// Reset is asynchronous and active low; all pad state returns to its reset values at once.
// The pressure percentage resets to 100; no clearing pass follows reset.
module gamepad_serial_command_responder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  gsc_in_if.sink                       in_i,
  gsc_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gsc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  gsc_pkg::item_t  in_item;
  gsc_pkg::stage_t stage;
  logic            take;
  logic [7:0]      level;

  assign in_item.opcode      = in_i.opcode;
  assign in_item.port_number = in_i.port_number;
  assign in_item.tx_byte     = in_i.tx_byte;
  assign in_item.buttons     = in_i.buttons;
  assign in_item.right_x     = in_i.right_x;
  assign in_item.right_y     = in_i.right_y;
  assign in_item.left_x      = in_i.left_x;
  assign in_item.left_y      = in_i.left_y;

  gsc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .level_o (level)
  );

  gsc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_item_i  (in_item),
    .take_i     (take),
    .stage_o    (stage)
  );

  gsc_resp u_resp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (stage),
    .level_i     (level),
    .take_o      (take),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .rx_byte_o   (out_o.rx_byte)
  );

endmodule
